FILE: hw/rtl/hlr_pkg.sv
// ----------------------------------------------------------------------------
// hlr_pkg: shared definitions for the horizontal linear resampler
// Register indexes, fixed field widths and the line store control bundle.
// ----------------------------------------------------------------------------
package hlr_pkg;

  localparam int PIX_W     = 8;
  localparam int RATE_W    = 24;
  localparam int LEN_CFG_W = 13;
  localparam int CFG_W     = 24;
  localparam int IDX_W     = 2;
  localparam int FRAC_W    = 16;
  localparam int LEN_RESET = 4096;

  localparam logic [IDX_W-1:0] REG_SCALE_RATE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_LINE_LENGTH = 2'd1;

  localparam logic [RATE_W-1:0] RATE_RESET = 24'h010000;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic wr_bank;
    logic rd_en;
    logic rd_bank;
  } hlr_mem_ctl_t;

endpackage

FILE: hw/rtl/horizontal_linear_resampler_core.sv
// ----------------------------------------------------------------------------
// horizontal_linear_resampler_core: one-line-delay horizontal linear resampler
// Stores the incoming line in one bank and blends the previous line from the
// other bank, one output pixel per input pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/pixel_in carries source pixels in raster
//   order. Each transfer yields exactly one result on out_valid/out_stall with
//   pixel_out, end_of_line and real_line, in the same order.
//   An input transfer passes through the read, weight and product stages and the output
//   register. Throughput is one pixel per cycle outside the clearing pass and while
//   out_stall is low: the line store reads both neighbors through two read ports
//   while the write goes to the other bank, so no item waits on another.
//   Configuration is written through cfg_write/cfg_index/cfg_data while no
//   item is in flight; index 0 is the 8.16 rate, index 1 the line length.
//   After reset both banks are cleared, one address per cycle in both banks,
//   with in_stall held high until the last address is written; configuration
//   writes are taken meanwhile. The first line out reads zeros with real_line low.
//   When the receiver stalls, the result holds and the pipeline fills; once
//   all four stages hold results, in_stall rises.
// ----------------------------------------------------------------------------
module horizontal_linear_resampler_core
  import hlr_pkg::*;
#(
  parameter int MAX_LINE = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 end_of_line,
  output logic                 real_line
);

  localparam int AW   = $clog2(MAX_LINE);
  localparam int LW   = $clog2(MAX_LINE + 1);
  localparam int LCW  = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
  localparam int PW   = RATE_W + AW;
  localparam int PH   = PW - FRAC_W;
  localparam int BW   = PH + 8;
  localparam int AWT  = BW + 2;
  localparam int M0W  = AWT + PIX_W + 1;
  localparam int M1W  = BW + PIX_W;
  localparam int SW   = M0W + 1;
  localparam int LRST = (MAX_LINE < LEN_RESET) ? MAX_LINE : LEN_RESET;

  // configuration
  logic [RATE_W-1:0] rate;
  logic [LW-1:0]     len_last;
  logic [LW-1:0]     len_lim;
  logic [LCW-1:0]    len_cfg;
  logic [LCW-1:0]    len_eff;

  assign len_cfg = LCW'(cfg_data[LEN_CFG_W-1:0]);
  assign len_eff = (len_cfg < LCW'(2)) ? LCW'(2) :
                   (len_cfg > LCW'(MAX_LINE)) ? LCW'(MAX_LINE) : len_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate     <= RATE_RESET;
      len_last <= LW'(LRST - 1);
      len_lim  <= LW'(LRST - 2);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE_RATE: begin
          rate <= cfg_data[RATE_W-1:0];
        end
        REG_LINE_LENGTH: begin
          len_last <= LW'(len_eff - LCW'(1));
          len_lim  <= LW'(len_eff - LCW'(2));
        end
        default: begin
        end
      endcase
    end
  end

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= AW'(clr_addr + AW'(1));
      if (clr_addr == AW'(MAX_LINE - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // pipeline flow
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv4;
  logic accept;

  assign adv4     = !out_valid || !out_stall;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = clearing || !adv1;
  assign accept   = in_valid && !in_stall;

  // line position state
  logic          write_bank;
  logic [AW-1:0] col;
  logic [PW-1:0] pos;
  logic          lines_seen;

  logic              last0;
  logic [PH-1:0]     pos_hi;
  logic [PH:0]       diff;
  logic              clamped;
  logic [AW-1:0]     idx;
  logic [PH-1:0]     hi0;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;

  assign last0     = LW'(col) >= len_last;
  assign pos_hi    = pos[PW-1:FRAC_W];
  assign diff      = {1'b0, pos_hi} - (PH + 1)'(len_lim);
  assign clamped   = !diff[PH] && (diff != '0);
  assign idx       = clamped ? len_lim[AW-1:0] : pos_hi[AW-1:0];
  assign hi0       = clamped ? diff[PH-1:0] : '0;
  assign rd_addr_a = last0 ? col : idx;
  assign rd_addr_b = AW'(idx + AW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      write_bank <= 1'b0;
      col        <= '0;
      pos        <= '0;
      lines_seen <= 1'b0;
    end else if (accept) begin
      if (last0) begin
        write_bank <= !write_bank;
        col        <= '0;
        pos        <= '0;
        lines_seen <= 1'b1;
      end else begin
        col <= AW'(col + AW'(1));
        pos <= PW'(pos + PW'(rate));
      end
    end
  end

  // line store
  hlr_mem_ctl_t     mem_ctl;
  logic [PIX_W-1:0] q_a, q_b;

  assign mem_ctl.clear   = clearing;
  assign mem_ctl.wr_en   = accept;
  assign mem_ctl.wr_bank = write_bank;
  assign mem_ctl.rd_en   = adv1;
  assign mem_ctl.rd_bank = !write_bank;

  hlr_line_store #(
    .DEPTH  (MAX_LINE),
    .ADDR_W (AW)
  ) u_line_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .wr_addr   (clearing ? clr_addr : col),
    .wr_data   (pixel_in),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (q_a),
    .rd_data_b (q_b)
  );

  // stage 1: addresses issued, read data arrives
  logic          last1, real1;
  logic [PH-1:0] hi1;
  logic [15:0]   frac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      last1 <= last0;
      real1 <= lines_seen;
      hi1   <= hi0;
      frac1 <= pos[FRAC_W-1:0];
    end
  end

  // stage 2: weights
  logic [BW-1:0]         b_next;
  logic                  c_next;
  logic signed [AWT-1:0] a_next;
  logic [BW-1:0]         b2;
  logic signed [AWT-1:0] a2;
  logic [PIX_W-1:0]      p0_2, p1_2;
  logic                  last2, real2;

  assign b_next = {hi1, frac1[15:8]};
  assign c_next = (hi1 == '0) && (frac1[7:0] != '0);
  assign a_next = AWT'(256) - AWT'(b_next) - AWT'(c_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      b2    <= b_next;
      a2    <= a_next;
      p0_2  <= q_a;
      p1_2  <= q_b;
      last2 <= last1;
      real2 <= real1;
    end
  end

  // stage 3: products
  logic signed [M0W-1:0] m0;
  logic [M1W-1:0]        m1;
  logic [PIX_W-1:0]      pass3;
  logic                  last3, real3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      m0    <= $signed({1'b0, p0_2}) * a2;
      m1    <= p1_2 * b2;
      pass3 <= p0_2;
      last3 <= last2;
      real3 <= real2;
    end
  end

  // stage 4: sum, saturate, output register
  logic signed [SW-1:0] sum;
  logic [PIX_W-1:0]     blended;

  assign sum = $signed({m0[M0W-1], m0}) + $signed({{(SW - M1W){1'b0}}, m1});

  always_comb begin
    if (sum[SW-1]) begin
      blended = '0;
    end else if (|sum[SW-2:16]) begin
      blended = '1;
    end else begin
      blended = sum[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      pixel_out   <= last3 ? pass3 : blended;
      end_of_line <= last3;
      real_line   <= real3;
    end
  end

endmodule

FILE: hw/rtl/hlr_line_store.sv
// ----------------------------------------------------------------------------
// hlr_line_store: double-banked line store
// Two banks with one write port each and two registered read ports.
// A clear writes zero to the same address in both banks.
// ----------------------------------------------------------------------------
module hlr_line_store
  import hlr_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  hlr_mem_ctl_t        ctl,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [PIX_W-1:0]    wr_data,
  input  logic [ADDR_W-1:0]   rd_addr_a,
  input  logic [ADDR_W-1:0]   rd_addr_b,
  output logic [PIX_W-1:0]    rd_data_a,
  output logic [PIX_W-1:0]    rd_data_b
);

  logic [PIX_W-1:0] bank0 [DEPTH];
  logic [PIX_W-1:0] bank1 [DEPTH];
  logic [PIX_W-1:0] a0, b0, a1, b1;
  logic             sel;
  logic [PIX_W-1:0] wdata;

  assign wdata = ctl.clear ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (ctl.clear || (ctl.wr_en && !ctl.wr_bank)) begin
      bank0[wr_addr] <= wdata;
    end
    if (ctl.clear || (ctl.wr_en && ctl.wr_bank)) begin
      bank1[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      a0  <= bank0[rd_addr_a];
      b0  <= bank0[rd_addr_b];
      a1  <= bank1[rd_addr_a];
      b1  <= bank1[rd_addr_b];
      sel <= ctl.rd_bank;
    end
  end

  assign rd_data_a = sel ? a1 : a0;
  assign rd_data_b = sel ? b1 : b0;

endmodule

FILE: hw/rtl/hlr_checker.sv
// ----------------------------------------------------------------------------
// hlr_port_checks: port-level checks for the horizontal linear resampler
// Watches the channels of the top level over time; bound to every instance.
// ----------------------------------------------------------------------------
module hlr_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] pixel_out,
  input logic       end_of_line,
  input logic       real_line
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) &&
      $stable(end_of_line) && $stable(real_line))
    else $error("stalled result changed");

  // drop nothing out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // block input during the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken before line store clear");

  // stay on the first line until its last column transfers
  a_first_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !end_of_line && !real_line
      |=> !(out_valid && real_line))
    else $error("real_line set inside first line");

endmodule

bind horizontal_linear_resampler_core hlr_port_checks u_hlr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_out   (pixel_out),
  .end_of_line (end_of_line),
  .real_line   (real_line)
);

FILE: tb/hlr_checker.sv
// ----------------------------------------------------------------------------
// hlr_checker: result predictor and comparator for the horizontal resampler
// Watches the configuration port and both channels, keeps its own copy of
// the double line store, predicts one output pixel per input transfer and
// compares every output transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module hlr_checker
  import hlr_pkg::*;
#(
  parameter int MAX_LINE = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     pixel_out,
  input  logic                 end_of_line,
  input  logic                 real_line,
  output int                   failures,
  output int                   outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LENGTH_RESET = 4096;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_col;
    logic             real_ln;
  } column_t;

  logic [RATE_W-1:0]    rate_q;
  logic [LEN_CFG_W-1:0] length_q;
  logic [PIX_W-1:0]     line_mem [2*MAX_LINE];
  logic                 bank_q;
  int unsigned          column_q;
  longint unsigned      position_q;
  logic                 seen_q;
  column_t              resampled_q[$];

  function automatic int unsigned active_length();
    int unsigned l;
    l = length_q;
    if (l < 2) l = 2;
    if (l > MAX_LINE) l = MAX_LINE;
    return l;
  endfunction

  function automatic logic [PIX_W-1:0] blend_neighbors(input int unsigned base,
                                                       input longint unsigned pos,
                                                       input int unsigned len);
    longint unsigned idx;
    longint          frac;
    longint          wt_right;
    longint          wt_left;
    longint          acc;
    idx = pos >> FRAC_W;
    if (idx > len - 2) idx = len - 2;
    frac     = longint'(pos - (idx << FRAC_W));
    wt_right = frac / 256;
    wt_left  = (65536 - frac) / 256;
    acc = longint'(line_mem[base + idx]) * wt_left
        + longint'(line_mem[base + idx + 1]) * wt_right;
    if (acc < 0) return '0;
    if (acc / 256 > 255) return '1;
    return PIX_W'(acc / 256);
  endfunction

  task automatic resample_column(input logic [PIX_W-1:0] pix, output column_t res);
    int unsigned len;
    int unsigned col;
    int unsigned rd_base;
    len = active_length();
    col = column_q;
    if (col >= MAX_LINE) col = MAX_LINE - 1;
    rd_base      = bank_q ? 0 : MAX_LINE;
    res.last_col = (col >= len - 1);
    res.pixel    = res.last_col ? line_mem[rd_base + col]
                                : blend_neighbors(rd_base, position_q, len);
    res.real_ln  = seen_q;
    line_mem[(bank_q ? MAX_LINE : 0) + col] = pix;
    if (res.last_col) begin
      bank_q     = ~bank_q;
      column_q   = 0;
      position_q = 0;
      seen_q     = 1'b1;
    end else begin
      column_q   = col + 1;
      position_q = position_q + rate_q;
    end
  endtask

  always @(posedge clk) begin : monitor
    column_t want;
    if (rst) begin
      rate_q     = RATE_RESET;
      length_q   = LEN_CFG_W'(LENGTH_RESET);
      bank_q     = 1'b0;
      column_q   = 0;
      position_q = 0;
      seen_q     = 1'b0;
      failures   = 0;
      foreach (line_mem[k]) line_mem[k] = '0;
      resampled_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SCALE_RATE:  rate_q = cfg_data[RATE_W-1:0];
          REG_LINE_LENGTH: length_q = cfg_data[LEN_CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        resample_column(pixel_in, want);
        resampled_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (resampled_q.size() == 0) begin
          failures++;
          $error("output transfer with nothing pending: pixel_out %0d", pixel_out);
        end else begin
          want = resampled_q.pop_front();
          if (pixel_out !== want.pixel) begin
            failures++;
            $error("pixel_out: expected %0d, actual %0d", want.pixel, pixel_out);
          end
          if (end_of_line !== want.last_col) begin
            failures++;
            $error("end_of_line: expected %0d, actual %0d", want.last_col, end_of_line);
          end
          if (real_line !== want.real_ln) begin
            failures++;
            $error("real_line: expected %0d, actual %0d", want.real_ln, real_line);
          end
        end
      end
    end
    outstanding <= resampled_q.size();
  end

endmodule

FILE: tb/horizontal_linear_resampler_core_tb.sv
// ----------------------------------------------------------------------------
// horizontal_linear_resampler_core_tb: stimulus and verdict for the resampler
// Drives directed lines over the pixel and register extremes, then random
// line formats and pixels with random idling on both channels, and a short
// run at the largest length. Checking is done by the attached checker.
// ----------------------------------------------------------------------------
module horizontal_linear_resampler_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import hlr_pkg::*;

  localparam int LINE_MAX    = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 340;
  localparam int TAIL_ITEMS   = 40;

  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   pixel_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic               end_of_line;
  logic               real_line;
  logic               steady = 1'b0;
  int                 failures;
  int                 outstanding;
  int                 cycles = 0;

  horizontal_linear_resampler_core #(
    .MAX_LINE (LINE_MAX)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .end_of_line (end_of_line),
    .real_line   (real_line)
  );

  hlr_checker #(
    .MAX_LINE (LINE_MAX)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .end_of_line (end_of_line),
    .real_line   (real_line),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** horizontal_linear_resampler_core: FAILED **");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // leaves cfg_write high; the caller lowers it after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_format(input logic [RATE_W-1:0] rate, input int unsigned len);
    wait_drained();
    write_reg(REG_SCALE_RATE, CFG_W'(rate));
    write_reg(REG_LINE_LENGTH, CFG_W'(len));
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       len;
    int unsigned       span;
    int unsigned       count;
    logic [RATE_W-1:0] rate;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_SPARE_A, CFG_W'($urandom));
    write_reg(REG_SPARE_B, '1);
    cfg_write <= 1'b0;

    set_format(RATE_RESET, 4);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd170);
    send_pixel(8'd85);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd128);

    set_format('0, 3);
    send_pixel(8'd7);
    send_pixel(8'd200);
    send_pixel(8'd33);

    set_format('1, 5);
    for (int k = 0; k < 5; k++) send_pixel(k[0] ? 8'd0 : 8'd255);

    set_format(24'h008000, 1);
    send_pixel(8'd99);
    send_pixel(8'd254);

    // run past the range, then shorten mid-line
    set_format(24'h018000, 8191);
    for (int k = 0; k < 6; k++) send_pixel(random_pixel());
    set_format(24'h018000, 3);
    send_pixel(random_pixel());

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: rate = '0;
        1: rate = '1;
        2: rate = RATE_W'($urandom_range(256, 1));
        3, 4: rate = RATE_W'($urandom);
        default: rate = RATE_W'($urandom_range(24'h028000, 24'h004000));
      endcase
      case ($urandom_range(15))
        0: len = 0;
        1: len = 1;
        2: len = $urandom_range(8191, LINE_MAX + 1);
        3: len = $urandom_range(200, 40);
        default: len = $urandom_range(24, 2);
      endcase
      span  = (len < 2) ? 2 : (len > 40 ? 40 : len);
      count = $urandom_range(3 * span, 1);
      set_format(rate, len);
      steady <= (sent >= 150 && sent < 260);
      for (int unsigned k = 0; k < count; k++) send_pixel(random_pixel());
      sent += count;
    end

    set_format(RATE_W'($urandom_range(24'h018000, 24'h004000)), LINE_MAX);
    steady <= 1'b0;
    for (int k = 0; k < TAIL_ITEMS; k++) send_pixel(random_pixel());

    wait_drained();
    if (failures == 0 && outstanding == 0) begin
      $display("** horizontal_linear_resampler_core: PASSED **");
    end else begin
      $display("** horizontal_linear_resampler_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hlr_pkg.sv
hw/rtl/hlr_line_store.sv
hw/rtl/horizontal_linear_resampler_core.sv
hw/rtl/hlr_checker.sv
tb/hlr_checker.sv
tb/horizontal_linear_resampler_core_tb.sv
